[design/nic_register_block_core_defines.svh]
// Assertion macros shared by the NIC register block RTL.
// Uses of these macros expect signals named clk and rst_n in the enclosing module.
`ifndef NIC_REGISTER_BLOCK_CORE_DEFINES_SVH
`define NIC_REGISTER_BLOCK_CORE_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define NRB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NRB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define NRB_ASSERT_IMP(label, ante, cons, msg)
`define NRB_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

[design/nrb_pkg.sv]
// Package for the NIC register block: request/response types, controller
// states and commands, register offsets and reset values. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nrb_pkg;

  typedef struct packed {
    logic        func;
    logic [2:0]  bar_select;
    logic [3:0]  access_size;
    logic [15:0] reg_offset;
    logic [31:0] write_data;
  } nrb_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_pulse;
    logic        unhandled;
    logic        tx_kick;
    logic        rx_inject_request;
  } nrb_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } nrb_state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } nrb_cmd_t;

  localparam logic       FUNC_READ  = 1'b0;
  localparam logic       FUNC_WRITE = 1'b1;
  localparam logic [2:0] BAR_MAIN   = 3'd0;
  localparam logic [3:0] SIZE_WORD  = 4'd4;

  localparam logic [15:0] OFF_CTRL   = 16'h0000;
  localparam logic [15:0] OFF_STATUS = 16'h0008;
  localparam logic [15:0] OFF_EERD   = 16'h0014;
  localparam logic [15:0] OFF_MDIC   = 16'h0020;
  localparam logic [15:0] OFF_ICR    = 16'h00c0;
  localparam logic [15:0] OFF_ICS    = 16'h00c8;
  localparam logic [15:0] OFF_IMS    = 16'h00d0;
  localparam logic [15:0] OFF_IMC    = 16'h00d8;
  localparam logic [15:0] OFF_RDBAL  = 16'h2800;
  localparam logic [15:0] OFF_RDBAH  = 16'h2804;
  localparam logic [15:0] OFF_RDLEN  = 16'h2808;
  localparam logic [15:0] OFF_RDH    = 16'h2810;
  localparam logic [15:0] OFF_RDT    = 16'h2818;
  localparam logic [15:0] OFF_TDBAL  = 16'h3800;
  localparam logic [15:0] OFF_TDBAH  = 16'h3804;
  localparam logic [15:0] OFF_TDLEN  = 16'h3808;
  localparam logic [15:0] OFF_TDH    = 16'h3810;
  localparam logic [15:0] OFF_TDT    = 16'h3818;

  localparam logic [31:0] STATUS_RESET = 32'h8008_0783;
  localparam logic [31:0] MDIC_RESET   = 32'h0800_0000;

  localparam logic [31:0] BASE_LO_MASK  = 32'hffff_ff80;
  localparam logic [31:0] EERD_DONE     = 32'h1100_0020;
  localparam logic [31:0] MDIC_ADDR_MASK = 32'h03ff_0000;
  localparam logic [31:0] MDIC_READY    = 32'h1000_0000;
  localparam logic [4:0]  PHY_REG_CTRL  = 5'd0;
  localparam logic [4:0]  PHY_REG_STAT  = 5'd1;
  localparam logic [15:0] PHY_CTRL_VAL  = 16'h1140;
  localparam logic [15:0] PHY_STAT_VAL  = 16'h796d;
  localparam logic [19:0] RING_MIN_BYTES = 20'd128;

  // A ring is usable when its base is nonzero and 128-byte aligned, its length
  // is a nonzero multiple of 128 and both pointers lie below length/16.
  function automatic logic ring_ok(input logic [63:0] base, input logic [19:0] bytes,
                                   input logic [15:0] head, input logic [15:0] tail);
    logic [15:0] entries;
    entries = bytes[19:4];
    return (base != 64'd0) && (base[6:0] == 7'd0) && (bytes >= RING_MIN_BYTES) &&
           (bytes[6:0] == 7'd0) && (head < entries) && (tail < entries);
  endfunction

endpackage

`default_nettype wire

[design/nrb_ctrl.sv]
// Sequencer for the NIC register block: IDLE -> EXEC -> RESP per request.
// Depends on nrb_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "nic_register_block_core_defines.svh"

module nrb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output nrb_pkg::nrb_cmd_t cmd
);
  import nrb_pkg::*;

  nrb_state_t state_r;
  nrb_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.execute = 1'b1;
        state_nxt   = ST_RESP;
      end
      ST_RESP: begin
        // hold the response until the sink takes it
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `NRB_ASSERT_IMP(a_ready_excl_valid, in_ready, !out_valid, "in_ready with out_valid")
  `NRB_ASSERT_NXT(a_capture_to_exec, cmd.capture, cmd.execute, "capture not followed by execute")
  `NRB_ASSERT_NXT(a_exec_to_resp, cmd.execute, out_valid, "execute not followed by response")

endmodule

`default_nettype wire

[design/nrb_dp.sv]
// Datapath for the NIC register block: request latch, register file,
// decode/update logic and response register. Depends on nrb_pkg and macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "nic_register_block_core_defines.svh"

module nrb_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  nrb_pkg::nrb_cmd_t cmd,
  input  nrb_pkg::nrb_req_t in_data,
  output nrb_pkg::nrb_rsp_t out_data
);
  import nrb_pkg::*;

  nrb_req_t req_r;
  nrb_rsp_t rsp_r;
  nrb_rsp_t rsp_nxt;

  logic [31:0] ctrl_r, ctrl_nxt;
  logic [31:0] status_r, status_nxt;
  logic [31:0] eerd_r, eerd_nxt;
  logic [31:0] mdic_r, mdic_nxt;
  logic [31:0] icr_r, icr_nxt;
  logic [31:0] ims_r, ims_nxt;
  logic [63:0] rx_base_r, rx_base_nxt;
  logic [63:0] tx_base_r, tx_base_nxt;
  logic [19:0] rx_len_r, rx_len_nxt;
  logic [19:0] tx_len_r, tx_len_nxt;
  logic [15:0] rx_head_r, rx_head_nxt;
  logic [15:0] rx_tail_r, rx_tail_nxt;
  logic [15:0] tx_head_r, tx_head_nxt;
  logic [15:0] tx_tail_r, tx_tail_nxt;

  logic        tail_wr;
  logic        rdt_wr;
  logic        rx_ok;
  logic        tx_ok;
  logic [4:0]  phy_reg;
  logic [15:0] phy_answer;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
    if (cmd.execute) begin
      rsp_r <= rsp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r    <= '0;
      status_r  <= STATUS_RESET;
      eerd_r    <= '0;
      mdic_r    <= MDIC_RESET;
      icr_r     <= '0;
      ims_r     <= '0;
      rx_base_r <= '0;
      tx_base_r <= '0;
      rx_len_r  <= '0;
      tx_len_r  <= '0;
      rx_head_r <= '0;
      rx_tail_r <= '0;
      tx_head_r <= '0;
      tx_tail_r <= '0;
    end else if (cmd.execute) begin
      ctrl_r    <= ctrl_nxt;
      status_r  <= status_nxt;
      eerd_r    <= eerd_nxt;
      mdic_r    <= mdic_nxt;
      icr_r     <= icr_nxt;
      ims_r     <= ims_nxt;
      rx_base_r <= rx_base_nxt;
      tx_base_r <= tx_base_nxt;
      rx_len_r  <= rx_len_nxt;
      tx_len_r  <= tx_len_nxt;
      rx_head_r <= rx_head_nxt;
      rx_tail_r <= rx_tail_nxt;
      tx_head_r <= tx_head_nxt;
      tx_tail_r <= tx_tail_nxt;
    end
  end

  assign phy_reg    = req_r.write_data[20:16];
  assign phy_answer = (phy_reg == PHY_REG_STAT) ? PHY_STAT_VAL :
                      ((phy_reg == PHY_REG_CTRL) ? PHY_CTRL_VAL : 16'h0000);

  // Validity sees the tail value being written in this request.
  assign rx_ok = ring_ok(rx_base_r, rx_len_r, rx_head_r, rx_tail_nxt);
  assign tx_ok = ring_ok(tx_base_r, tx_len_r, tx_head_r, tx_tail_nxt);

  always_comb begin
    ctrl_nxt    = ctrl_r;
    status_nxt  = status_r;
    eerd_nxt    = eerd_r;
    mdic_nxt    = mdic_r;
    icr_nxt     = icr_r;
    ims_nxt     = ims_r;
    rx_base_nxt = rx_base_r;
    tx_base_nxt = tx_base_r;
    rx_len_nxt  = rx_len_r;
    tx_len_nxt  = tx_len_r;
    rx_head_nxt = rx_head_r;
    rx_tail_nxt = rx_tail_r;
    tx_head_nxt = tx_head_r;
    tx_tail_nxt = tx_tail_r;
    rsp_nxt     = '0;
    tail_wr     = 1'b0;
    rdt_wr      = 1'b0;

    if ((req_r.bar_select != BAR_MAIN) || (req_r.access_size != SIZE_WORD)) begin
      rsp_nxt.unhandled = 1'b1;
    end else if (req_r.func == FUNC_READ) begin
      case (req_r.reg_offset)
        OFF_ICR: begin
          // read clears the cause register
          rsp_nxt.read_data = icr_r;
          icr_nxt           = '0;
        end
        OFF_CTRL:   rsp_nxt.read_data = ctrl_r;
        OFF_STATUS: rsp_nxt.read_data = status_r;
        OFF_EERD:   rsp_nxt.read_data = eerd_r;
        OFF_MDIC:   rsp_nxt.read_data = mdic_r;
        OFF_IMS:    rsp_nxt.read_data = ims_r;
        OFF_RDLEN:  rsp_nxt.read_data = {12'd0, rx_len_r};
        OFF_RDH:    rsp_nxt.read_data = {16'd0, rx_head_r};
        OFF_RDT:    rsp_nxt.read_data = {16'd0, rx_tail_r};
        OFF_TDLEN:  rsp_nxt.read_data = {12'd0, tx_len_r};
        OFF_TDH:    rsp_nxt.read_data = {16'd0, tx_head_r};
        OFF_TDT:    rsp_nxt.read_data = {16'd0, tx_tail_r};
        OFF_RDBAL:  rsp_nxt.read_data = rx_base_r[31:0];
        OFF_RDBAH:  rsp_nxt.read_data = rx_base_r[63:32];
        OFF_TDBAL:  rsp_nxt.read_data = tx_base_r[31:0];
        OFF_TDBAH:  rsp_nxt.read_data = tx_base_r[63:32];
        default:    rsp_nxt.unhandled = 1'b1;
      endcase
    end else begin
      case (req_r.reg_offset)
        OFF_RDBAL: rx_base_nxt[31:0]  = req_r.write_data & BASE_LO_MASK;
        OFF_TDBAL: tx_base_nxt[31:0]  = req_r.write_data & BASE_LO_MASK;
        OFF_RDBAH: rx_base_nxt[63:32] = req_r.write_data;
        OFF_TDBAH: tx_base_nxt[63:32] = req_r.write_data;
        OFF_ICS: begin
          icr_nxt           = icr_r | req_r.write_data;
          rsp_nxt.irq_pulse = |(ims_r & req_r.write_data);
        end
        OFF_IMC: ims_nxt = ims_r & ~req_r.write_data;
        OFF_EERD: eerd_nxt = EERD_DONE | {31'd0, req_r.write_data[0]};
        OFF_MDIC: begin
          mdic_nxt = (req_r.write_data & MDIC_ADDR_MASK) | MDIC_READY | {16'd0, phy_answer};
        end
        OFF_ICR: begin
          // accept and drop
        end
        OFF_IMS: begin
          ims_nxt           = ims_r | req_r.write_data;
          rsp_nxt.irq_pulse = |(icr_r & req_r.write_data);
        end
        OFF_CTRL:   ctrl_nxt    = req_r.write_data;
        OFF_STATUS: status_nxt  = req_r.write_data;
        OFF_RDLEN:  rx_len_nxt  = {req_r.write_data[19:7], 7'd0};
        OFF_TDLEN:  tx_len_nxt  = {req_r.write_data[19:7], 7'd0};
        OFF_RDH:    rx_head_nxt = req_r.write_data[15:0];
        OFF_TDH:    tx_head_nxt = req_r.write_data[15:0];
        OFF_RDT: begin
          rx_tail_nxt = req_r.write_data[15:0];
          tail_wr     = 1'b1;
          rdt_wr      = 1'b1;
        end
        OFF_TDT: begin
          tx_tail_nxt = req_r.write_data[15:0];
          tail_wr     = 1'b1;
        end
        default: rsp_nxt.unhandled = 1'b1;
      endcase
    end

    rsp_nxt.tx_kick = tail_wr && rx_ok && tx_ok &&
                      (tx_head_r != tx_tail_nxt) && (rx_head_r != rx_tail_nxt);
    rsp_nxt.rx_inject_request = rdt_wr && (rx_tail_nxt != rx_tail_r) &&
                                !rsp_nxt.tx_kick && rx_ok && (rx_head_r != rx_tail_nxt);
  end

  assign out_data = rsp_r;

  `NRB_ASSERT_NXT(a_unh_reads_zero, cmd.execute,
                  !(rsp_r.unhandled && (rsp_r.read_data != 32'd0)),
                  "unhandled access returned data")
  `NRB_ASSERT_NXT(a_kick_inject_excl, cmd.execute,
                  !(rsp_r.tx_kick && rsp_r.rx_inject_request),
                  "tx kick and rx inject together")
  `NRB_ASSERT_IMP(a_irq_from_ics_ims, cmd.execute && rsp_nxt.irq_pulse,
                  (req_r.func == FUNC_WRITE) &&
                  ((req_r.reg_offset == OFF_ICS) || (req_r.reg_offset == OFF_IMS)),
                  "irq pulse without ICS or IMS write")

endmodule

`default_nettype wire

[design/nic_register_block_core.sv]
// NIC register block (e1000-style register file), one 32-bit BAR access per request.
//
// Channels: in_valid/in_ready carry one access (in_data: func, BAR, size, offset,
// write data); out_valid/out_ready return one response per request (out_data: read
// data, irq pulse, unhandled flag, tx kick and rx inject doorbells).
// An accepted request is latched in IDLE, then decoded and committed in EXEC, and
// its response is valid from the commit until taken. The sequencer handles one
// request at a time (accept, execute, deliver), so the block takes no new request
// until the last response is taken. A stalled sink holds the response and keeps
// in_ready low; nothing is dropped.
// Reset (rst_n low, synchronous) returns the sequencer to idle and loads the
// register file reset values: STATUS 0x80080783, MDIC 0x08000000, all else zero.
// Depends on nrb_pkg, nrb_ctrl and nrb_dp.
`timescale 1ns / 1ps
`default_nettype none

module nic_register_block_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  nrb_pkg::nrb_req_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output nrb_pkg::nrb_rsp_t out_data
);
  import nrb_pkg::*;

  nrb_cmd_t cmd;

  nrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  nrb_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
